FILE: design/sbd_pkg.sv
// ----------------------------------------------------------------------------
// Sequence bytecode decoder package
// Parse phase codes, event kind codes, the command tables and the decoded
// event type shared by the decoder and its output stage.
// ----------------------------------------------------------------------------
package sbd_pkg;

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_KEY   = 3'd1;
    localparam logic [2:0] PH_PARAM = 3'd2;
    localparam logic [2:0] PH_TIME1 = 3'd3;
    localparam logic [2:0] PH_TIME2 = 3'd4;
    localparam logic [2:0] PH_DUR1  = 3'd5;
    localparam logic [2:0] PH_DUR2  = 3'd6;
    localparam logic [2:0] PH_VEL   = 3'd7;

    localparam logic [4:0] EV_NOTE       = 5'd0;
    localparam logic [4:0] EV_RELNOTE    = 5'd1;
    localparam logic [4:0] EV_END        = 5'd2;
    localparam logic [4:0] EV_PORTA_ON   = 5'd13;
    localparam logic [4:0] EV_PORTA_OFF  = 5'd14;
    localparam logic [4:0] EV_ENVELOPE   = 5'd15;
    localparam logic [4:0] EV_VOICECLASS = 5'd16;
    localparam logic [4:0] EV_NOOP       = 5'd17;

    localparam logic [4:0] CMD_END       = 5'd0;
    localparam logic [4:0] CMD_PAN       = 5'd5;
    localparam logic [4:0] CMD_PORTA_ON  = 5'd14;
    localparam logic [4:0] CMD_PORTA_OFF = 5'd15;
    localparam logic [4:0] CMD_TABLE_VLQ = 5'h1f;

    localparam logic [7:0] KEY_RESET      = 8'd60;
    localparam logic [7:0] VELOCITY_RESET = 8'd127;
    localparam logic [7:0] PAN_MAX        = 8'h7f;
    localparam logic [15:0] TIMING_NONE   = 16'hffff;

    typedef struct packed {
        logic [4:0]  event_kind;
        logic [7:0]  key;
        logic [7:0]  previous_key;
        logic        glide;
        logic [7:0]  velocity;
        logic [15:0] note_length;
        logic [15:0] wait_ticks;
        logic [7:0]  param_a;
        logic [7:0]  param_b;
        logic [7:0]  param_c;
        logic [7:0]  param_d;
    } evt_t;

    // Number of parameter bytes that follow a control status byte.
    function automatic logic [2:0] param_count(input logic [4:0] cmd);
        logic [2:0] n;
        unique case (cmd) inside
            5'd0, 5'd11, 5'd12, 5'd15:          n = 3'd0;
            5'd7, 5'd10:                        n = 3'd2;
            5'd8:                               n = 3'd4;
            [5'd1:5'd6], 5'd9, 5'd13, 5'd14:    n = 3'd1;
            [5'd16:5'd21]:                      n = 3'd1;
            default:                            n = 3'd0;
        endcase
        return n;
    endfunction

    // Event kind reported for a control command.
    function automatic logic [4:0] ctrl_kind(input logic [4:0] cmd);
        logic [4:0] k;
        unique case (cmd) inside
            [5'd1:5'd10]:   k = cmd + 5'd2;
            CMD_PORTA_ON:   k = EV_PORTA_ON;
            CMD_PORTA_OFF:  k = EV_PORTA_OFF;
            [5'd16:5'd20]:  k = EV_ENVELOPE;
            5'd21:          k = EV_VOICECLASS;
            default:        k = EV_NOOP;
        endcase
        return k;
    endfunction

endpackage

FILE: design/sequence_bytecode_decoder_core.sv
// ----------------------------------------------------------------------------
// Sequence bytecode decoder
// Parses a music-sequence bytecode one byte per word and emits one decoded
// event on the last byte of each command; also loads the duration table.
// ----------------------------------------------------------------------------
//  channel  | direction | tdata (low bit first)                | tuser
//  ---------+-----------+--------------------------------------+------------
//  s_*      | in        | byte_value, table_index, table_value | action
//  m_*      | out       | key .. param_d (see port comment)    | event_kind
//
// One input word is taken per cycle while s_tready is high; its event, if any,
// is registered at the accepting edge, in the output register or the skid entry.
// The parse state machine and the held note state update in that same cycle.
// Reset sets parse and held state to reset values and clears the 32-entry duration table.
// s_tready drops only while the output register and its skid entry are both
// full, and rises again once m_tready takes the waiting word.
module sequence_bytecode_decoder_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // byte_value[7:0], table_index[12:8], table_value[28:13]
    input  logic        s_tuser,  // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,  // key, previous_key, glide, velocity, note_length,
                                  // wait_ticks, param_a, param_b, param_c, param_d
    output logic [4:0]  m_tuser   // event_kind
);

    logic       acc;
    logic       seq_take;
    logic [7:0] byte_in;
    logic [4:0] tbl_idx;
    logic [15:0] tbl_val;

    logic [2:0]       phase_reg, phase_next;
    logic [7:0]       status_reg, status_next;
    logic [3:0][7:0]  par_reg, par_next;
    logic [2:0]       pcnt_reg, pcnt_next;
    logic [7:0]       vfirst_reg, vfirst_next;
    logic [15:0]      ptime_reg, ptime_next;
    logic             tvalid_reg, tvalid_next;
    logic [15:0]      plen_reg, plen_next;
    logic [15:0]      tlen_reg, tlen_next;
    logic [15:0]      delta_reg, delta_next;
    logic [15:0]      ndelta_reg, ndelta_next;
    logic [15:0]      length_reg, length_next;
    logic [7:0]       velocity_reg, velocity_next;
    logic [7:0]       key_reg, key_next;
    logic             porta_en_reg, porta_en_next;
    logic [7:0]       porta_time_reg, porta_time_next;
    logic             had_note_reg, had_note_next;
    logic             ended_reg, ended_next;
    logic [15:0]      dur_table_reg [32];

    logic             emit;
    sbd_pkg::evt_t    evt;
    logic             room;
    logic             out_valid;
    sbd_pkg::evt_t    out_evt;

    assign byte_in  = s_tdata[7:0];
    assign tbl_idx  = s_tdata[12:8];
    assign tbl_val  = s_tdata[28:13];
    assign s_tready = room;
    assign acc      = s_tvalid && room;
    assign seq_take = acc && s_tuser && !ended_reg;

    always_comb
    begin
        logic        do_start;
        logic        do_after_t;
        logic        do_after_d;
        logic        do_fin_note;
        logic        do_fin_ctrl;
        logic        vel_valid;
        logic [2:0]  pcnt_inc;
        logic [4:0]  cmd;
        logic [7:0]  key_step;
        logic [7:0]  prev;
        logic [15:0] d;

        do_start    = 1'b0;
        do_after_t  = 1'b0;
        do_after_d  = 1'b0;
        do_fin_note = 1'b0;
        do_fin_ctrl = 1'b0;
        vel_valid   = 1'b0;
        pcnt_inc    = pcnt_reg + 3'd1;
        cmd         = 5'd0;
        key_step    = {4'd0, byte_in[3:0]};
        prev        = key_reg;
        d           = delta_reg;

        phase_next      = phase_reg;
        status_next     = status_reg;
        par_next        = par_reg;
        pcnt_next       = pcnt_reg;
        vfirst_next     = vfirst_reg;
        ptime_next      = ptime_reg;
        tvalid_next     = tvalid_reg;
        plen_next       = plen_reg;
        tlen_next       = tlen_reg;
        delta_next      = delta_reg;
        ndelta_next     = ndelta_reg;
        length_next     = length_reg;
        velocity_next   = velocity_reg;
        key_next        = key_reg;
        porta_en_next   = porta_en_reg;
        porta_time_next = porta_time_reg;
        had_note_next   = had_note_reg;
        ended_next      = ended_reg;

        emit = 1'b0;
        evt  = '0;

        unique case (phase_reg)
            sbd_pkg::PH_IDLE:
            begin
                status_next = byte_in;
                par_next    = '0;
                pcnt_next   = 3'd0;
                tvalid_next = 1'b0;
                tlen_next   = dur_table_reg[byte_in[4:0]];
                if (!byte_in[7])
                begin
                    phase_next = sbd_pkg::PH_KEY;
                end
                else if (byte_in[6:5] == 2'b01)
                begin
                    key_next      = byte_in[4] ? key_reg + key_step : key_reg - key_step;
                    delta_next    = ndelta_reg;
                    had_note_next = 1'b1;
                    emit                 = 1'b1;
                    evt.event_kind       = sbd_pkg::EV_RELNOTE;
                    evt.key              = key_next;
                    evt.previous_key     = prev;
                    evt.glide            = porta_en_reg && had_note_reg
                                           && (porta_time_reg != 8'd0) && (prev != key_next);
                    evt.velocity         = velocity_reg;
                    evt.note_length      = length_reg;
                    evt.wait_ticks       = ndelta_reg;
                end
                else if (byte_in[4:0] == sbd_pkg::CMD_END)
                begin
                    ended_next       = 1'b1;
                    emit             = 1'b1;
                    evt.event_kind   = sbd_pkg::EV_END;
                    evt.key          = key_reg;
                    evt.previous_key = key_reg;
                    evt.velocity     = velocity_reg;
                    evt.note_length  = length_reg;
                end
                else if (sbd_pkg::param_count(byte_in[4:0]) != 3'd0)
                begin
                    phase_next = sbd_pkg::PH_PARAM;
                end
                else
                begin
                    do_start = 1'b1;
                end
            end
            sbd_pkg::PH_KEY:
            begin
                par_next[0] = byte_in;
                do_start    = 1'b1;
            end
            sbd_pkg::PH_PARAM:
            begin
                par_next[pcnt_reg[1:0]] = byte_in;
                pcnt_next               = pcnt_inc;
                if (pcnt_inc >= sbd_pkg::param_count(status_reg[4:0]))
                begin
                    do_start = 1'b1;
                end
            end
            sbd_pkg::PH_TIME1:
            begin
                if (status_reg[6:5] == 2'b11)
                begin
                    ptime_next  = dur_table_reg[byte_in[4:0]];
                    tvalid_next = 1'b1;
                    do_after_t  = 1'b1;
                end
                else if (byte_in[7])
                begin
                    vfirst_next = byte_in;
                    phase_next  = sbd_pkg::PH_TIME2;
                end
                else
                begin
                    ptime_next  = {8'd0, byte_in};
                    tvalid_next = 1'b1;
                    do_after_t  = 1'b1;
                end
            end
            sbd_pkg::PH_TIME2:
            begin
                ptime_next  = {2'd0, vfirst_reg[6:0], byte_in[6:0]};
                tvalid_next = 1'b1;
                do_after_t  = 1'b1;
            end
            sbd_pkg::PH_DUR1:
            begin
                if (byte_in[7])
                begin
                    vfirst_next = byte_in;
                    phase_next  = sbd_pkg::PH_DUR2;
                end
                else
                begin
                    plen_next  = {8'd0, byte_in};
                    do_after_d = 1'b1;
                end
            end
            sbd_pkg::PH_DUR2:
            begin
                plen_next  = {2'd0, vfirst_reg[6:0], byte_in[6:0]};
                do_after_d = 1'b1;
            end
            sbd_pkg::PH_VEL:
            begin
                par_next[1] = byte_in;
                vel_valid   = 1'b1;
                do_fin_note = 1'b1;
            end
            default:
            begin
                phase_next = sbd_pkg::PH_IDLE;
            end
        endcase

        if (do_start)
        begin
            if (status_next[6])
            begin
                phase_next = sbd_pkg::PH_TIME1;
            end
            else
            begin
                tvalid_next = 1'b0;
                ptime_next  = sbd_pkg::TIMING_NONE;
                do_after_t  = 1'b1;
            end
        end

        if (do_after_t)
        begin
            if (!status_next[7])
            begin
                if (status_next[4:0] == sbd_pkg::CMD_TABLE_VLQ)
                begin
                    phase_next = sbd_pkg::PH_DUR1;
                end
                else
                begin
                    plen_next  = tlen_reg;
                    do_after_d = 1'b1;
                end
            end
            else
            begin
                do_fin_ctrl = 1'b1;
            end
        end

        if (do_after_d)
        begin
            if (par_next[0][7])
            begin
                phase_next = sbd_pkg::PH_VEL;
            end
            else
            begin
                do_fin_note = 1'b1;
            end
        end

        if (do_fin_note)
        begin
            key_next    = {1'b0, par_next[0][6:0]};
            length_next = plen_next;
            if (status_next[6:5] == 2'b01)
            begin
                d = plen_next;
            end
            if (tvalid_next)
            begin
                d = ptime_next;
            end
            delta_next  = d;
            ndelta_next = d;
            if (vel_valid)
            begin
                velocity_next = par_next[1];
            end
            had_note_next    = 1'b1;
            emit             = 1'b1;
            evt.event_kind   = sbd_pkg::EV_NOTE;
            evt.key          = key_next;
            evt.previous_key = prev;
            evt.glide        = porta_en_reg && had_note_reg
                               && (porta_time_reg != 8'd0) && (prev != key_next);
            evt.velocity     = velocity_next;
            evt.note_length  = length_next;
            evt.wait_ticks   = d;
        end

        if (do_fin_ctrl)
        begin
            cmd              = status_next[4:0];
            evt.event_kind   = sbd_pkg::ctrl_kind(cmd);
            evt.param_a      = par_next[0];
            evt.param_b      = par_next[1];
            evt.param_c      = par_next[2];
            evt.param_d      = par_next[3];
            if ((cmd == sbd_pkg::CMD_PAN) && (par_next[0] > sbd_pkg::PAN_MAX))
            begin
                evt.param_a = sbd_pkg::PAN_MAX;
            end
            if (evt.event_kind == sbd_pkg::EV_ENVELOPE)
            begin
                evt.param_b = par_next[0];
                evt.param_a = {3'd0, cmd - 5'd16};
            end
            if (cmd == sbd_pkg::CMD_PORTA_ON)
            begin
                porta_en_next   = 1'b1;
                porta_time_next = par_next[0];
            end
            if (cmd == sbd_pkg::CMD_PORTA_OFF)
            begin
                porta_en_next = 1'b0;
            end
            if (tvalid_next)
            begin
                d = ptime_next;
            end
            delta_next       = d;
            emit             = 1'b1;
            evt.key          = key_reg;
            evt.previous_key = key_reg;
            evt.velocity     = velocity_reg;
            evt.note_length  = length_reg;
            evt.wait_ticks   = d;
        end

        if (emit)
        begin
            phase_next = sbd_pkg::PH_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= sbd_pkg::PH_IDLE;
            status_reg     <= 8'd0;
            par_reg        <= '0;
            pcnt_reg       <= 3'd0;
            vfirst_reg     <= 8'd0;
            ptime_reg      <= sbd_pkg::TIMING_NONE;
            tvalid_reg     <= 1'b0;
            plen_reg       <= 16'd0;
            tlen_reg       <= 16'd0;
            delta_reg      <= 16'd0;
            ndelta_reg     <= 16'd0;
            length_reg     <= 16'd0;
            velocity_reg   <= sbd_pkg::VELOCITY_RESET;
            key_reg        <= sbd_pkg::KEY_RESET;
            porta_en_reg   <= 1'b0;
            porta_time_reg <= 8'd0;
            had_note_reg   <= 1'b0;
            ended_reg      <= 1'b0;
            for (int i = 0; i < 32; i++)
            begin
                dur_table_reg[i] <= 16'd0;
            end
        end
        else if (acc && !s_tuser)
        begin
            dur_table_reg[tbl_idx] <= tbl_val;
            // Keep the duration fetched for the current status byte coherent.
            if (tbl_idx == status_reg[4:0])
            begin
                tlen_reg <= tbl_val;
            end
        end
        else if (seq_take)
        begin
            phase_reg      <= phase_next;
            status_reg     <= status_next;
            par_reg        <= par_next;
            pcnt_reg       <= pcnt_next;
            vfirst_reg     <= vfirst_next;
            ptime_reg      <= ptime_next;
            tvalid_reg     <= tvalid_next;
            plen_reg       <= plen_next;
            tlen_reg       <= tlen_next;
            delta_reg      <= delta_next;
            ndelta_reg     <= ndelta_next;
            length_reg     <= length_next;
            velocity_reg   <= velocity_next;
            key_reg        <= key_next;
            porta_en_reg   <= porta_en_next;
            porta_time_reg <= porta_time_next;
            had_note_reg   <= had_note_next;
            ended_reg      <= ended_next;
        end
    end

    sbd_out_skid u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (seq_take && emit),
        .push_evt  (evt),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (m_tready),
        .out_evt   (out_evt)
    );

    assign m_tvalid = out_valid;
    assign m_tuser  = out_evt.event_kind;
    assign m_tdata  = {7'd0, out_evt.param_d, out_evt.param_c, out_evt.param_b,
                       out_evt.param_a, out_evt.wait_ticks, out_evt.note_length,
                       out_evt.velocity, out_evt.glide, out_evt.previous_key,
                       out_evt.key};

    a_silent_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        ended_reg |-> !(seq_take && emit))
        else $error("event produced after the end command");

    a_glide_only_notes: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_take && emit && evt.glide) |->
            (evt.event_kind == sbd_pkg::EV_NOTE || evt.event_kind == sbd_pkg::EV_RELNOTE))
        else $error("glide flagged on a non-note event");

    a_event_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_take && emit) |=> (phase_reg == sbd_pkg::PH_IDLE))
        else $error("parser not idle after an event");

    a_end_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_take && emit && evt.event_kind == sbd_pkg::EV_END) |=> ended_reg)
        else $error("end event did not stop the parser");

endmodule

FILE: design/sbd_out_skid.sv
// ----------------------------------------------------------------------------
// Sequence bytecode decoder output stage
// Output register plus one skid entry, so the decoder keeps taking words
// while a finished event waits at the master side.
// ----------------------------------------------------------------------------
module sbd_out_skid (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  sbd_pkg::evt_t push_evt,
    output logic          room,
    output logic          out_valid,
    input  logic          out_ready,
    output sbd_pkg::evt_t out_evt
);

    logic          out_valid_reg;
    logic          skid_valid_reg;
    sbd_pkg::evt_t out_evt_reg;
    sbd_pkg::evt_t skid_evt_reg;
    logic          drain;

    assign drain     = out_valid_reg && out_ready;
    assign room      = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_evt   = out_evt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (drain)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !out_ready)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (drain)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (drain)
            begin
                out_evt_reg <= skid_evt_reg;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !out_ready)
            begin
                skid_evt_reg <= push_evt;
            end
            else
            begin
                out_evt_reg <= push_evt;
            end
        end
    end

    // The skid entry is only ever filled behind a waiting output word.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds a word while the output register is empty");

    // A push is never offered while the skid entry is occupied.
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> !push)
        else $error("event pushed while the output stage is full");

endmodule
